// File: hw/rtl/cbl_pkg.sv
// ---------------------------------------------------------------------------
// cbl_pkg
// Shared character codes, lexer state codes, status codes and types for the
// CSV byte lexer.
// ---------------------------------------------------------------------------
package cbl_pkg;

   // characters with a meaning to the lexer
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_COMMA = 8'h2C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_SPACE = 8'h20;

   // lexer state codes
   localparam logic [2:0] LX_ROW        = 3'd0;
   localparam logic [2:0] LX_PAD_PRE    = 3'd1;
   localparam logic [2:0] LX_PAD_END    = 3'd2;
   localparam logic [2:0] LX_QUOTED     = 3'd3;
   localparam logic [2:0] LX_QUOTE_SEEN = 3'd4;
   localparam logic [2:0] LX_UNQUOTED   = 3'd5;
   localparam logic [2:0] LX_COMMA      = 3'd6;
   localparam logic [2:0] LX_CR         = 3'd7;

   // status codes
   localparam logic [2:0] ST_RUN       = 3'd0;
   localparam logic [2:0] ST_LIMIT     = 3'd1;
   localparam logic [2:0] ST_END       = 3'd2;
   localparam logic [2:0] ST_BARE_LF   = 3'd3;
   localparam logic [2:0] ST_BAD_QUOTE = 3'd4;
   localparam logic [2:0] ST_BAD_PAD   = 3'd5;
   localparam logic [2:0] ST_CR_NO_LF  = 3'd6;
   localparam logic [2:0] ST_HALTED    = 3'd7;

   // decision taken by the lexer for one byte
   typedef struct packed {
      logic [2:0] next_state;
      logic       char_valid;
      logic       value_end;
      logic       row_end;
      logic [2:0] status;
   } cbl_decode_type;

   // one result item as held in the output register
   typedef struct packed {
      logic        char_valid;
      logic [7:0]  char_out;
      logic        value_end;
      logic        row_end;
      logic [2:0]  status;
      logic [31:0] byte_position;
   } cbl_result_type;

endpackage

// File: hw/rtl/cbl_step.sv
// ---------------------------------------------------------------------------
// cbl_step
// Transition logic of the lexer: from the current state and one byte, the
// next state, the value and row flags and any syntax error.
// ---------------------------------------------------------------------------
module cbl_step import cbl_pkg::*; (
   input  logic [2:0]     lex_state,
   input  logic [7:0]     data_byte,
   output cbl_decode_type decode
);

   // character classes
   logic is_quote, is_comma, is_cr, is_lf, is_space;

   assign is_quote = (data_byte == CH_QUOTE);
   assign is_comma = (data_byte == CH_COMMA);
   assign is_cr    = (data_byte == CH_CR);
   assign is_lf    = (data_byte == CH_LF);
   assign is_space = (data_byte == CH_SPACE);

   // per-state transition table
   always_comb begin
      decode            = '0;
      decode.next_state = lex_state;
      decode.status     = ST_RUN;
      unique case (lex_state)
         LX_QUOTED: begin
            if (is_quote) decode.next_state = LX_QUOTE_SEEN;
            else          decode.char_valid = 1'b1;
         end
         LX_UNQUOTED: begin
            priority if (is_quote || is_space) decode.next_state = LX_QUOTE_SEEN;
            else if (is_comma) begin
               decode.value_end  = 1'b1;
               decode.next_state = LX_COMMA;
            end
            else if (is_cr) decode.next_state = LX_CR;
            else if (is_lf) begin
               decode.value_end  = 1'b1;
               decode.row_end    = 1'b1;
               decode.next_state = LX_ROW;
            end
            else decode.char_valid = 1'b1;
         end
         LX_PAD_PRE: begin
            priority if (is_space) decode.next_state = LX_PAD_PRE;
            else if (is_cr) decode.next_state = LX_CR;
            else if (is_comma) begin
               decode.value_end  = 1'b1;
               decode.next_state = LX_COMMA;
            end
            else if (is_lf) begin
               decode.value_end  = 1'b1;
               decode.row_end    = 1'b1;
               decode.next_state = LX_ROW;
            end
            else if (is_quote) decode.next_state = LX_QUOTED;
            else begin
               decode.char_valid = 1'b1;
               decode.next_state = LX_UNQUOTED;
            end
         end
         LX_QUOTE_SEEN: begin
            // doubled quote gives a literal quote
            priority if (is_quote) begin
               decode.char_valid = 1'b1;
               decode.next_state = LX_QUOTED;
            end
            else if (is_space) decode.next_state = LX_PAD_END;
            else if (is_cr) decode.next_state = LX_CR;
            else if (is_lf) begin
               decode.value_end  = 1'b1;
               decode.row_end    = 1'b1;
               decode.next_state = LX_ROW;
            end
            else if (is_comma) begin
               decode.value_end  = 1'b1;
               decode.next_state = LX_COMMA;
            end
            else decode.status = ST_BAD_QUOTE;
         end
         LX_PAD_END: begin
            priority if (is_space) decode.next_state = LX_PAD_END;
            else if (is_comma) begin
               decode.value_end  = 1'b1;
               decode.next_state = LX_COMMA;
            end
            else if (is_cr) decode.next_state = LX_CR;
            else if (is_lf) begin
               decode.value_end  = 1'b1;
               decode.row_end    = 1'b1;
               decode.next_state = LX_ROW;
            end
            else decode.status = ST_BAD_PAD;
         end
         LX_COMMA: begin
            priority if (is_lf) begin
               decode.value_end  = 1'b1;
               decode.row_end    = 1'b1;
               decode.next_state = LX_ROW;
            end
            else if (is_cr) decode.next_state = LX_CR;
            else if (is_space) decode.next_state = LX_PAD_PRE;
            else if (is_quote) decode.next_state = LX_QUOTED;
            else if (is_comma) begin
               decode.value_end  = 1'b1;
               decode.next_state = LX_COMMA;
            end
            else begin
               decode.char_valid = 1'b1;
               decode.next_state = LX_UNQUOTED;
            end
         end
         LX_CR: begin
            if (is_lf) begin
               decode.value_end  = 1'b1;
               decode.row_end    = 1'b1;
               decode.next_state = LX_ROW;
            end
            else decode.status = ST_CR_NO_LF;
         end
         default: begin
            // row start
            priority if (is_lf) decode.status = ST_BARE_LF;
            else if (is_cr) decode.next_state = LX_CR;
            else if (is_comma) begin
               decode.value_end  = 1'b1;
               decode.next_state = LX_COMMA;
            end
            else if (is_quote) decode.next_state = LX_QUOTED;
            else if (is_space) decode.next_state = LX_PAD_PRE;
            else begin
               decode.char_valid = 1'b1;
               decode.next_state = LX_UNQUOTED;
            end
         end
      endcase
   end

endmodule

// File: hw/rtl/csv_byte_lexer.sv
// ---------------------------------------------------------------------------
// csv_byte_lexer
// Byte-serial CSV tokenizer: one result item for every input byte.
// ---------------------------------------------------------------------------
// Each accepted byte gives exactly one result item in the next cycle, and a
// new byte is accepted in every cycle while the output register is empty or
// being taken, so the block runs at one byte per cycle; the lexer transition,
// the row count and the position count are all computed combinationally.
// row_limit (zero means no limit) must be written via csr_wr_en / csr_wr_data
// only while idle; the block does not enforce this. Any status but running
// halts the block until reset: later bytes report halted and change nothing.
module csv_byte_lexer import cbl_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   // configuration
   input  logic        csr_wr_en,
   input  logic [15:0] csr_wr_data,
   // input bytes
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_last_byte,
   // result items
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_char_valid,
   output logic [7:0]  rsp_char_out,
   output logic        rsp_value_end,
   output logic        rsp_row_end,
   output logic [2:0]  rsp_status,
   output logic [31:0] rsp_byte_position
);

   logic [15:0]    row_limit_ff, row_limit_in;
   logic [2:0]     lex_state_ff, lex_state_in;
   logic [15:0]    rows_done_ff, rows_done_in;
   logic [31:0]    position_ff, position_in;
   logic           halted_ff, halted_in;
   logic           rsp_valid_ff, rsp_valid_in;
   cbl_result_type result_ff, result_in;

   cbl_decode_type decode;
   logic           accept;
   logic [15:0]    rows_next;
   logic           limit_hit;
   logic [2:0]     status;

   // lexer transition for the offered byte
   cbl_step u_step (
      .lex_state (lex_state_ff),
      .data_byte (req_data_byte),
      .decode    (decode)
   );

   // output register frees up when empty or being taken
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   // row count after this byte and the limit check
   assign rows_next = (rows_done_ff == 16'hFFFF) ? rows_done_ff : rows_done_ff + 16'd1;
   assign limit_hit = (row_limit_ff != 16'd0) && (rows_next >= row_limit_ff);

   // status of this byte: halted first, then errors, then row limit, then input end
   always_comb begin
      priority if (halted_ff)                status = ST_HALTED;
      else if (decode.status != ST_RUN)      status = decode.status;
      else if (decode.row_end && limit_hit)  status = ST_LIMIT;
      else if (req_last_byte)                status = ST_END;
      else                                   status = ST_RUN;
   end

   // next values of state and result
   always_comb begin
      row_limit_in = csr_wr_en ? csr_wr_data : row_limit_ff;
      lex_state_in = lex_state_ff;
      rows_done_in = rows_done_ff;
      position_in  = position_ff;
      halted_in    = halted_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      result_in    = result_ff;

      if (accept) begin
         rsp_valid_in            = 1'b1;
         result_in               = '0;
         result_in.status        = status;
         result_in.byte_position = position_ff;
         if (!halted_ff) begin
            result_in.char_valid = decode.char_valid;
            result_in.char_out   = decode.char_valid ? req_data_byte : 8'd0;
            result_in.value_end  = decode.value_end;
            result_in.row_end    = decode.row_end;
            if (decode.status == ST_RUN) begin
               lex_state_in = decode.next_state;
               if (decode.row_end) rows_done_in = rows_next;
            end
            halted_in = (status != ST_RUN);
            if (position_ff != 32'hFFFF_FFFF) position_in = position_ff + 32'd1;
         end
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_limit_ff <= 16'd0;
         lex_state_ff <= LX_ROW;
         rows_done_ff <= 16'd0;
         position_ff  <= 32'd0;
         halted_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         row_limit_ff <= row_limit_in;
         lex_state_ff <= lex_state_in;
         rows_done_ff <= rows_done_in;
         position_ff  <= position_in;
         halted_ff    <= halted_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // result payload
   always_ff @(posedge clock) begin
      result_ff <= result_in;
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_char_valid    = result_ff.char_valid;
   assign rsp_char_out      = result_ff.char_out;
   assign rsp_value_end     = result_ff.value_end;
   assign rsp_row_end       = result_ff.row_end;
   assign rsp_status        = result_ff.status;
   assign rsp_byte_position = result_ff.byte_position;

endmodule

// File: hw/rtl/cbl_checker.sv
// ---------------------------------------------------------------------------
// cbl_checker
// Port-level checks for the CSV byte lexer, bound to the top level.
// ---------------------------------------------------------------------------
module cbl_checker import cbl_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic        rsp_char_valid,
   input logic [7:0]  rsp_char_out,
   input logic        rsp_value_end,
   input logic        rsp_row_end,
   input logic [2:0]  rsp_status
);

   logic stopped_ff, stopped_in;

   // remembers that a stopping status has been delivered
   assign stopped_in = stopped_ff || (rsp_valid && !rsp_stall && (rsp_status != ST_RUN));

   always_ff @(posedge clock) begin
      if (reset) stopped_ff <= 1'b0;
      else       stopped_ff <= stopped_in;
   end

   // a stalled item stays offered
   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_char_out) && $stable(rsp_status))
      else $error("result item dropped while stalled");

   // once stopped, every later item reports halted with no flags
   a_halted: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && stopped_ff |-> rsp_status == ST_HALTED && !rsp_char_valid
         && !rsp_value_end && !rsp_row_end)
      else $error("item after a stop is not reported as halted");

   // syntax errors carry no flags
   a_error_flags: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_BARE_LF || rsp_status == ST_BAD_QUOTE
         || rsp_status == ST_BAD_PAD || rsp_status == ST_CR_NO_LF)
      |-> !rsp_char_valid && !rsp_value_end && !rsp_row_end)
      else $error("syntax error item carries flags");

   // a row end closes a value, a row limit comes only with a row end
   a_row_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (!rsp_row_end || rsp_value_end) && (rsp_status != ST_LIMIT || rsp_row_end)
         && !(rsp_char_valid && rsp_value_end))
      else $error("inconsistent value and row flags");

endmodule

bind csv_byte_lexer cbl_checker u_cbl_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_char_valid (rsp_char_valid),
   .rsp_char_out   (rsp_char_out),
   .rsp_value_end  (rsp_value_end),
   .rsp_row_end    (rsp_row_end),
   .rsp_status     (rsp_status)
);

// File: bench/csv_byte_lexer_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// csv_byte_lexer_test
// Self-checking bench for the CSV byte lexer. A short table of hand-picked
// bytes walks every lexer state, then random CSV rows and guarded noise run
// under three row limits. The run closes on one halting cause drawn at
// random and a burst of ignored bytes. Every result item is checked field by
// field against its typed table row or the bench's cycle-free lexer model.
// ---------------------------------------------------------------------------
module csv_byte_lexer_test;
   import cbl_pkg::*;

   localparam int CYCLE_LIMIT = 400000;

   // one row of the directed table; expected fields only matter when typed
   typedef struct packed {
      logic [7:0] data_byte;
      logic       last_byte;
      logic       typed;
      logic       exp_char_valid;
      logic [7:0] exp_char_out;
      logic       exp_value_end;
      logic       exp_row_end;
      logic [2:0] exp_status;
   } directed_row_type;

   typedef enum int {
      STOP_INPUT, STOP_LIMIT, STOP_BARE_LF, STOP_BAD_QUOTE, STOP_BAD_PAD, STOP_CR_NO_LF
   } stop_cause_type;

   // every lexer state, starting straight from reset, with no error
   localparam directed_row_type DIRECTED [27] = '{
      '{8'hFF,    1'b0, 1'b1, 1'b1, 8'hFF, 1'b0, 1'b0, ST_RUN},
      '{8'h00,    1'b0, 1'b1, 1'b1, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_COMMA, 1'b0, 1'b1, 1'b0, 8'h00, 1'b1, 1'b0, ST_RUN},
      '{CH_QUOTE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_COMMA, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_QUOTE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_QUOTE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_LF,    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_QUOTE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_SPACE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_SPACE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_COMMA, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_SPACE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_SPACE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{8'h61,    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_SPACE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_CR,    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_LF,    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_CR,    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_LF,    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_COMMA, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_COMMA, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_CR,    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_LF,    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_QUOTE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_QUOTE, 1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN},
      '{CH_LF,    1'b0, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0, ST_RUN}
   };

   logic        clock;
   logic        reset;
   logic        csr_wr_en;
   logic [15:0] csr_wr_data;
   logic        req_valid;
   logic        req_stall;
   logic [7:0]  req_data_byte;
   logic        req_last_byte;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic        rsp_char_valid;
   logic [7:0]  rsp_char_out;
   logic        rsp_value_end;
   logic        rsp_row_end;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_byte_position;

   // bench copy of the lexer state, counters, halt flag and row limit
   logic [2:0]  lx_state = LX_ROW;
   logic [15:0] rows_seen = '0;
   logic [31:0] next_pos = '0;
   logic        halted = 1'b0;
   logic [15:0] row_cap = '0;

   cbl_result_type pending_lex_results[$];
   int fault_count = 0;
   int bytes_sent = 0;
   int cycle_count = 0;
   int stall_left = 0;
   bit req_quiet = 1'b0;
   bit rsp_quiet = 1'b0;

   csv_byte_lexer dut (
      .clock(clock),
      .reset(reset),
      .csr_wr_en(csr_wr_en),
      .csr_wr_data(csr_wr_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_last_byte(req_last_byte),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_char_valid(rsp_char_valid),
      .rsp_char_out(rsp_char_out),
      .rsp_value_end(rsp_value_end),
      .rsp_row_end(rsp_row_end),
      .rsp_status(rsp_status),
      .rsp_byte_position(rsp_byte_position)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // transition of the lexer for one byte, without the counters
   function automatic cbl_decode_type lex_decode(input logic [2:0] s, input logic [7:0] b);
      cbl_decode_type d;
      d = '0;
      d.next_state = s;
      d.status = ST_RUN;
      case (s)
         LX_QUOTED: begin
            if (b == CH_QUOTE) d.next_state = LX_QUOTE_SEEN;
            else d.char_valid = 1'b1;
         end
         LX_UNQUOTED: begin
            if (b == CH_QUOTE || b == CH_SPACE) d.next_state = LX_QUOTE_SEEN;
            else if (b == CH_COMMA) begin d.value_end = 1'b1; d.next_state = LX_COMMA; end
            else if (b == CH_CR) d.next_state = LX_CR;
            else if (b == CH_LF) begin
               d.value_end = 1'b1; d.row_end = 1'b1; d.next_state = LX_ROW;
            end
            else d.char_valid = 1'b1;
         end
         LX_PAD_PRE: begin
            if (b == CH_SPACE) d.next_state = LX_PAD_PRE;
            else if (b == CH_CR) d.next_state = LX_CR;
            else if (b == CH_COMMA) begin d.value_end = 1'b1; d.next_state = LX_COMMA; end
            else if (b == CH_LF) begin
               d.value_end = 1'b1; d.row_end = 1'b1; d.next_state = LX_ROW;
            end
            else if (b == CH_QUOTE) d.next_state = LX_QUOTED;
            else begin d.char_valid = 1'b1; d.next_state = LX_UNQUOTED; end
         end
         LX_QUOTE_SEEN: begin
            // a second quote is a literal one, anything unexpected is an error
            if (b == CH_QUOTE) begin d.char_valid = 1'b1; d.next_state = LX_QUOTED; end
            else if (b == CH_SPACE) d.next_state = LX_PAD_END;
            else if (b == CH_CR) d.next_state = LX_CR;
            else if (b == CH_LF) begin
               d.value_end = 1'b1; d.row_end = 1'b1; d.next_state = LX_ROW;
            end
            else if (b == CH_COMMA) begin d.value_end = 1'b1; d.next_state = LX_COMMA; end
            else d.status = ST_BAD_QUOTE;
         end
         LX_PAD_END: begin
            if (b == CH_SPACE) d.next_state = LX_PAD_END;
            else if (b == CH_COMMA) begin d.value_end = 1'b1; d.next_state = LX_COMMA; end
            else if (b == CH_CR) d.next_state = LX_CR;
            else if (b == CH_LF) begin
               d.value_end = 1'b1; d.row_end = 1'b1; d.next_state = LX_ROW;
            end
            else d.status = ST_BAD_PAD;
         end
         LX_COMMA: begin
            if (b == CH_LF) begin
               d.value_end = 1'b1; d.row_end = 1'b1; d.next_state = LX_ROW;
            end
            else if (b == CH_CR) d.next_state = LX_CR;
            else if (b == CH_SPACE) d.next_state = LX_PAD_PRE;
            else if (b == CH_QUOTE) d.next_state = LX_QUOTED;
            else if (b == CH_COMMA) begin d.value_end = 1'b1; d.next_state = LX_COMMA; end
            else begin d.char_valid = 1'b1; d.next_state = LX_UNQUOTED; end
         end
         LX_CR: begin
            if (b == CH_LF) begin
               d.value_end = 1'b1; d.row_end = 1'b1; d.next_state = LX_ROW;
            end
            else d.status = ST_CR_NO_LF;
         end
         default: begin
            if (b == CH_LF) d.status = ST_BARE_LF;
            else if (b == CH_CR) d.next_state = LX_CR;
            else if (b == CH_COMMA) begin d.value_end = 1'b1; d.next_state = LX_COMMA; end
            else if (b == CH_QUOTE) d.next_state = LX_QUOTED;
            else if (b == CH_SPACE) d.next_state = LX_PAD_PRE;
            else begin d.char_valid = 1'b1; d.next_state = LX_UNQUOTED; end
         end
      endcase
      return d;
   endfunction

   // full result for one byte, advancing the bench state
   function automatic cbl_result_type lex_byte(input logic [7:0] b, input logic lst);
      cbl_decode_type d;
      cbl_result_type r;
      r = '0;
      r.byte_position = next_pos;
      if (halted) begin
         r.status = ST_HALTED;
         return r;
      end
      d = lex_decode(lx_state, b);
      if (d.status == ST_RUN) begin
         lx_state = d.next_state;
         if (d.row_end) begin
            if (rows_seen != '1) rows_seen++;
            if (row_cap != 0 && rows_seen >= row_cap) d.status = ST_LIMIT;
         end
         if (d.status == ST_RUN && lst) d.status = ST_END;
      end
      if (d.status != ST_RUN) halted = 1'b1;
      if (next_pos != '1) next_pos++;
      r.char_valid = d.char_valid;
      r.char_out = d.char_valid ? b : 8'h00;
      r.value_end = d.value_end;
      r.row_end = d.row_end;
      r.status = d.status;
      return r;
   endfunction

   function automatic int draw_gap(input bit quiet);
      return quiet ? 0 : $urandom_range(0, 12);
   endfunction

   // any byte that can stand inside an unquoted value
   function automatic logic [7:0] pick_plain();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255));
      while (b inside {CH_QUOTE, CH_COMMA, CH_CR, CH_LF, CH_SPACE});
      return b;
   endfunction

   // hand one item to the lexer and note what it should give back
   task automatic push_byte(input logic [7:0] b, input logic lst,
                            input bit typed = 1'b0, input cbl_result_type typed_res = '0);
      int gap;
      cbl_result_type r;
      if ($urandom_range(0, 49) == 0) req_quiet = !req_quiet;
      gap = draw_gap(req_quiet);
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_last_byte <= lst;
      do @(posedge clock);
      while (req_stall);
      r = lex_byte(b, lst);
      pending_lex_results.push_back(typed ? typed_res : r);
      bytes_sent++;
   endtask

   task automatic write_row_limit(input logic [15:0] v);
      csr_wr_en <= 1'b1;
      csr_wr_data <= v;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      row_cap = v;
   endtask

   // stop sending and let every outstanding result come back
   task automatic drain();
      req_valid <= 1'b0;
      do @(posedge clock);
      while (pending_lex_results.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   // bring the lexer back to the start of a row without an error
   task automatic close_row();
      if (lx_state == LX_QUOTED) push_byte(CH_QUOTE, 1'b0);
      if (lx_state != LX_ROW) push_byte(CH_LF, 1'b0);
   endtask

   // one well-formed row with random fields, padding and line ending
   task automatic send_row();
      int fields;
      int len;
      bit quoted;
      logic [7:0] b;
      logic lst;
      fields = $urandom_range(1, 5);
      for (int f = 0; f < fields; f++) begin
         if (f != 0) push_byte(CH_COMMA, 1'b0);
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) push_byte(CH_SPACE, 1'b0);
         quoted = ($urandom_range(0, 2) == 0);
         len = $urandom_range(0, 6);
         if (quoted) begin
            push_byte(CH_QUOTE, 1'b0);
            repeat (len) begin
               b = 8'($urandom_range(0, 255));
               push_byte(b, 1'b0);
               if (b == CH_QUOTE) push_byte(CH_QUOTE, 1'b0);
            end
            push_byte(CH_QUOTE, 1'b0);
         end else begin
            repeat (len) push_byte(pick_plain(), 1'b0);
         end
         if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) push_byte(CH_SPACE, 1'b0);
      end
      // an empty row needs CR LF, a lone LF there would be an error
      if (lx_state == LX_ROW || $urandom_range(0, 1) == 0) push_byte(CH_CR, 1'b0);
      // on the row that reaches the limit, sometimes flag the end of input too
      lst = (row_cap != 0 && int'(rows_seen) + 1 >= int'(row_cap)) ?
            1'($urandom_range(0, 1)) : 1'b0;
      push_byte(CH_LF, lst);
   endtask

   // mostly rows, with bursts of noise that never trip an error
   task automatic random_phase(input int count);
      int start;
      logic [7:0] b;
      cbl_decode_type d;
      start = bytes_sent;
      while (bytes_sent - start < count) begin
         if ($urandom_range(0, 3) == 0) begin
            repeat ($urandom_range(1, 8)) begin
               do begin
                  b = 8'($urandom_range(0, 255));
                  d = lex_decode(lx_state, b);
               end while (d.status != ST_RUN);
               push_byte(b, 1'b0);
            end
            // noise can stop anywhere, so finish its row before the next one
            close_row();
         end else begin
            send_row();
         end
      end
      // leave the lexer at the start of a row
      close_row();
   endtask

   task automatic note_field(input string name, input logic [31:0] want, input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         fault_count++;
      end
   endtask

   // result side: check each accepted item, then hold off for a random while
   always @(posedge clock) begin
      cbl_result_type want;
      if (!reset) begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_lex_results.size() == 0) begin
               $error("result item with none expected");
               fault_count++;
            end else begin
               want = pending_lex_results.pop_front();
               note_field("char_valid", 32'(want.char_valid), 32'(rsp_char_valid));
               note_field("char_out", 32'(want.char_out), 32'(rsp_char_out));
               note_field("value_end", 32'(want.value_end), 32'(rsp_value_end));
               note_field("row_end", 32'(want.row_end), 32'(rsp_row_end));
               note_field("status", 32'(want.status), 32'(rsp_status));
               note_field("byte_position", want.byte_position, rsp_byte_position);
            end
            if ($urandom_range(0, 49) == 0) rsp_quiet = !rsp_quiet;
            stall_left = draw_gap(rsp_quiet);
         end else if (stall_left > 0) begin
            stall_left--;
         end
         rsp_stall <= (stall_left != 0);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   initial begin
      cbl_result_type r;
      stop_cause_type cause;
      logic [7:0] b;
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_wr_data <= '0;
      req_valid <= 1'b0;
      req_data_byte <= '0;
      req_last_byte <= 1'b0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed table under the largest row limit
      write_row_limit(16'hFFFF);
      foreach (DIRECTED[i]) begin
         r = '0;
         r.char_valid = DIRECTED[i].exp_char_valid;
         r.char_out = DIRECTED[i].exp_char_out;
         r.value_end = DIRECTED[i].exp_value_end;
         r.row_end = DIRECTED[i].exp_row_end;
         r.status = DIRECTED[i].exp_status;
         r.byte_position = 32'(i);
         push_byte(DIRECTED[i].data_byte, DIRECTED[i].last_byte, DIRECTED[i].typed, r);
      end

      // random text under several row limits
      random_phase(550);
      drain();
      write_row_limit(16'h0000);
      random_phase(550);
      drain();
      write_row_limit(16'($urandom_range(1000, 60000)));
      random_phase(500);

      // finish on one halting cause
      cause = stop_cause_type'($urandom_range(0, 5));
      case (cause)
         STOP_INPUT: begin
            repeat ($urandom_range(0, 3)) send_row();
            push_byte(pick_plain(), 1'b1);
         end
         STOP_LIMIT: begin
            drain();
            write_row_limit(16'(rows_seen + $urandom_range(1, 3)));
            while (!halted) send_row();
         end
         STOP_BARE_LF: push_byte(CH_LF, 1'($urandom_range(0, 1)));
         STOP_BAD_QUOTE: begin
            push_byte(CH_QUOTE, 1'b0);
            push_byte(pick_plain(), 1'b0);
            push_byte(CH_QUOTE, 1'b0);
            push_byte(pick_plain(), 1'($urandom_range(0, 1)));
         end
         STOP_BAD_PAD: begin
            push_byte(CH_QUOTE, 1'b0);
            push_byte(CH_QUOTE, 1'b0);
            push_byte(CH_SPACE, 1'b0);
            push_byte(pick_plain(), 1'($urandom_range(0, 1)));
         end
         default: begin
            push_byte(CH_CR, 1'b0);
            do b = 8'($urandom_range(0, 255));
            while (b == CH_LF);
            push_byte(b, 1'($urandom_range(0, 1)));
         end
      endcase

      // once halted, every byte is ignored
      repeat (20) push_byte(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));

      drain();
      repeat (4) @(posedge clock);
      if (fault_count == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
